FILE: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/bde_pkg.sv
// types and constants for the button debouncer
package bde_pkg;

    // timer width used for the elapsed-time arithmetic
    localparam int TIME_BITS = 32;
    localparam int NOW_W     = 32;
    localparam int MS_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = MS_W;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOW = 2'd0,
        CFG_PRESS_MS   = 2'd1,
        CFG_RELEASE_MS = 2'd2
    } cfg_idx_t;

    // status codes of a result word
    typedef enum logic [2:0] {
        ST_PRESSED       = 3'd0,
        ST_RELEASED      = 3'd1,
        ST_JUST_PRESSED  = 3'd2,
        ST_JUST_RELEASED = 3'd3,
        ST_IDLE          = 3'd4
    } status_t;

    // one pin sample as it travels between the stages
    typedef struct packed {
        logic             pin_level;
        logic [NOW_W-1:0] now_ms;
    } sample_t;

    // reset values of the press and release time registers
    localparam logic [MS_W-1:0] PRESS_MS_RST   = 16'd30;
    localparam logic [MS_W-1:0] RELEASE_MS_RST = 16'd40;

endpackage

FILE: sv/bde_if.sv
// handshake interfaces for the sample and status channels
interface bde_sample_if;
    logic        valid;
    logic        ready;
    logic        pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bde_status_if;
    logic       valid;
    logic       ready;
    logic [2:0] button_status;

    modport source (output valid, output button_status, input ready);
    modport sink   (input valid, input button_status, output ready);
endinterface

FILE: sv/bde_core.sv
// debounce state, configuration registers and status decision
module bde_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bde_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          step,
    input  bde_pkg::sample_t              sample,
    output bde_pkg::status_t              status
);
    import bde_pkg::*;

    logic                 active_low_reg;
    logic [MS_W-1:0]      press_ms_reg;
    logic [MS_W-1:0]      release_ms_reg;

    logic                 accepted_level_reg, accepted_level_next;
    status_t              reported_reg, reported_next;
    logic [TIME_BITS-1:0] window_start_reg, window_start_next;
    logic                 debouncing_reg, debouncing_next;

    logic                 level_diff;
    logic                 pressed;
    logic [MS_W-1:0]      need;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 timed_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg <= 1'b1;
            press_ms_reg   <= PRESS_MS_RST;
            release_ms_reg <= RELEASE_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                CFG_PRESS_MS:   press_ms_reg   <= cfg_data[MS_W-1:0];
                CFG_RELEASE_MS: release_ms_reg <= cfg_data[MS_W-1:0];
                default:        ;
            endcase
        end
    end

    // window timing, wrapping subtraction
    assign level_diff = sample.pin_level != accepted_level_reg;
    assign pressed    = sample.pin_level ^ active_low_reg;
    assign need       = pressed ? press_ms_reg : release_ms_reg;
    assign now_t      = TIME_BITS'(sample.now_ms);
    assign elapsed    = now_t - window_start_reg;
    assign timed_out  = elapsed >= TIME_BITS'(need);

    // status and next state for the sample in hand
    always_comb
    begin
        accepted_level_next = accepted_level_reg;
        reported_next       = reported_reg;
        window_start_next   = window_start_reg;
        debouncing_next     = debouncing_reg;
        status              = ST_IDLE;
        if (level_diff)
        begin
            if (!debouncing_reg)
            begin
                debouncing_next   = 1'b1;
                window_start_next = now_t;
            end
            else if (timed_out)
            begin
                accepted_level_next = sample.pin_level;
                debouncing_next     = 1'b0;
                reported_next       = pressed ? ST_JUST_PRESSED : ST_JUST_RELEASED;
                status              = reported_next;
            end
        end
        else if (!debouncing_reg)
        begin
            case (reported_reg)
                ST_JUST_PRESSED:  reported_next = ST_PRESSED;
                ST_JUST_RELEASED: reported_next = ST_RELEASED;
                default:          reported_next = reported_reg;
            endcase
            status = reported_next;
        end
    end

    // debounce state, updated once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_level_reg <= 1'b1;
            reported_reg       <= ST_RELEASED;
            window_start_reg   <= '0;
            debouncing_reg     <= 1'b0;
        end
        else if (step)
        begin
            accepted_level_reg <= accepted_level_next;
            reported_reg       <= reported_next;
            window_start_reg   <= window_start_next;
            debouncing_reg     <= debouncing_next;
        end
    end

endmodule

FILE: sv/button_debounce_edge_state.sv
// top level of the button debouncer with press and release events
//
// Usage: one word on the sample channel carries a raw pin level and a
// millisecond timestamp; for each word exactly one word leaves on the status
// channel (0 pressed, 1 released, 2 just pressed, 3 just released, 4 idle).
// Both channels use valid/ready; a word moves when both are high.
// An accepted sample passes through the sample register, the decision logic,
// then the status register. Throughput is one word per cycle while the
// status channel takes its words, set by the single pass through the sample
// register, the decision logic and the status register.
// A stalled status word holds in its register; the sample register still
// takes a new word and is drained as soon as the status register frees up,
// so the sample channel stalls only when both registers are full.
// Reset starts released with the pin level high, active low polarity,
// 30 ms press time and 40 ms release time. The user must write registers on the
// configuration port only while no word is in flight; the block does not enforce it.
`include "assert_macros.svh"

module button_debounce_edge_state (
    input  logic                          clk,
    input  logic                          rst_n,
    bde_sample_if.sink                    sample,
    bde_status_if.source                  status,
    input  logic                          cfg_we,
    input  logic [bde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bde_pkg::CFG_W-1:0]     cfg_data
);
    import bde_pkg::*;

    logic    in_fire;
    logic    stage_valid_reg;
    sample_t stage_reg;
    logic    stage_move;
    logic    out_valid_reg;
    status_t out_status_reg;
    status_t step_status;

    // handshakes
    assign stage_move   = stage_valid_reg && (!out_valid_reg || status.ready);
    assign sample.ready = !stage_valid_reg || stage_move;
    assign in_fire      = sample.valid && sample.ready;

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            stage_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg.pin_level <= sample.pin_level;
            stage_reg.now_ms    <= sample.now_ms;
        end
    end

    // decision logic and debounce state
    bde_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (stage_move),
        .sample    (stage_reg),
        .status    (step_status)
    );

    // status register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_move)
        begin
            out_status_reg <= step_status;
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.button_status = out_status_reg;

    // checks on the two-stage pipeline
    `ASSERT_NEXT(a_fire_fills_stage, clk, rst_n, in_fire, stage_valid_reg)
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_reg && !stage_move, stage_valid_reg)
    `ASSERT_NEXT(a_move_gives_word, clk, rst_n, stage_move, out_valid_reg)
    `ASSERT_SAME(a_status_code, clk, rst_n, out_valid_reg, out_status_reg <= ST_IDLE)

endmodule
